@@ src/tile_filename_parser_macros.svh @@
// Assertion macros shared by the tile file name parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TILE_FILENAME_PARSER_MACROS_SVH
`define TILE_FILENAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define TFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tile_filename_parser: check failed");
// next-cycle implication, disabled during reset
`define TFP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tile_filename_parser: check failed");
`else
`define TFP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TFP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ src/tfp_pkg.sv @@
// Types and constants of the tile file name parser: beat payloads,
// extension tables and character codes. No dependencies.
`timescale 1ns / 1ps

package tfp_pkg;

    typedef logic [7:0] t_byte;

    // Number of extension names and how many of them are regular ones
    localparam int EXT_COUNT     = 13;
    localparam int REGULAR_COUNT = 8;
    localparam int MAX_EXT_LEN   = 8;
    localparam int EXT_POS_W     = $clog2(MAX_EXT_LEN);
    localparam int POS_W         = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAVORS_EN = 1'd1;

    // File types
    localparam logic [2:0] TYPE_META    = 3'd0;
    localparam logic [2:0] TYPE_MESH    = 3'd1;
    localparam logic [2:0] TYPE_ATLAS   = 3'd2;
    localparam logic [2:0] TYPE_NAVTILE = 3'd3;
    localparam logic [2:0] TYPE_META2D  = 3'd4;
    localparam logic [2:0] TYPE_MASK    = 3'd5;
    localparam logic [2:0] TYPE_ORTHO   = 3'd6;
    localparam logic [2:0] TYPE_CREDITS = 3'd7;

    // Flavors
    localparam logic [1:0] FLAVOR_REGULAR = 2'd0;
    localparam logic [1:0] FLAVOR_RAW     = 2'd1;
    localparam logic [1:0] FLAVOR_DEBUG   = 2'd2;

    // Character codes
    localparam t_byte CH_NUL  = 8'h00;
    localparam t_byte CH_DASH = 8'h2D;
    localparam t_byte CH_DOT  = 8'h2E;
    localparam t_byte CH_ZERO = 8'h30;
    localparam t_byte CH_NINE = 8'h39;

    // Extension spellings, zero padded
    localparam t_byte EXT_TEXT [EXT_COUNT][MAX_EXT_LEN] = '{
        '{"m", "e", "t", "a", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"b", "i", "n", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"j", "p", "g", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"n", "a", "v", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"2", "d", "m", "e", "t", "a", CH_NUL, CH_NUL},
        '{"m", "a", "s", "k", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"o", "r", "t", "h", "o", CH_NUL, CH_NUL, CH_NUL},
        '{"c", "r", "e", "d", "i", "t", "s", CH_NUL},
        '{"r", "m", "e", "s", "h", CH_NUL, CH_NUL, CH_NUL},
        '{"r", "a", "t", "l", "a", "s", CH_NUL, CH_NUL},
        '{"r", "n", "a", "v", "t", "i", "l", "e"},
        '{"m", "e", "t", "a", ".", "d", "b", "g"},
        '{"m", "a", "s", "k", ".", "d", "b", "g"}
    };

    localparam logic [POS_W-1:0] EXT_LEN [EXT_COUNT] = '{
        4'd4, 4'd3, 4'd3, 4'd3, 4'd6, 4'd4, 4'd5, 4'd7, 4'd5, 4'd6, 4'd8, 4'd8, 4'd8
    };

    localparam logic [2:0] EXT_TYPE [EXT_COUNT] = '{
        TYPE_META, TYPE_MESH, TYPE_ATLAS, TYPE_NAVTILE, TYPE_META2D, TYPE_MASK,
        TYPE_ORTHO, TYPE_CREDITS, TYPE_MESH, TYPE_ATLAS, TYPE_NAVTILE, TYPE_META,
        TYPE_MASK
    };

    localparam logic [1:0] EXT_FLAVOR [EXT_COUNT] = '{
        FLAVOR_REGULAR, FLAVOR_REGULAR, FLAVOR_REGULAR, FLAVOR_REGULAR,
        FLAVOR_REGULAR, FLAVOR_REGULAR, FLAVOR_REGULAR, FLAVOR_REGULAR,
        FLAVOR_RAW, FLAVOR_RAW, FLAVOR_RAW, FLAVOR_DEBUG, FLAVOR_DEBUG
    };

    // Input beat: one character of the name
    typedef struct packed {
        t_byte char_code;
        logic  is_last;
    } t_char_beat;

    // Configuration write beat
    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        t_byte                write_data;
    } t_cfg_beat;

    // Result beat
    typedef struct packed {
        logic        name_valid;
        logic [7:0]  level_of_detail;
        logic [31:0] tile_x;
        logic [31:0] tile_y;
        logic [31:0] sub_file;
        logic        has_sub_file;
        logic [2:0]  file_type;
        logic [1:0]  flavor_code;
    } t_result;

    // Extension lookup outcome
    typedef struct packed {
        logic       found;
        logic [2:0] file_type;
        logic [1:0] flavor;
    } t_ext_hit;

endpackage

@@ src/tfp_stream_if.sv @@
// Valid/ready channel carrying one payload struct per beat.
// Payload types come from tfp_pkg at the instantiation site.
`timescale 1ns / 1ps

interface tfp_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/tile_filename_parser.sv @@
// Channel        | Dir | Payload                      | Beat accepted when
// i_chars        | in  | char_code, is_last           | valid && ready
// o_result       | out | name_valid .. flavor_code    | valid && ready
// i_cfg          | in  | reg_index, write_data        | valid && ready (ready tied high)
//
// One character per cycle unless a last character waits on a full result register:
// a beat is held in the input register, then the parse core updates its state; a
// last character also loads the result register, which then presents the result.
// Reset clears the parse state and sets skip_count 0, flavors_enabled 1.
// Only a last character waits on a full result register; later characters wait behind it.
// Depends on tfp_pkg, tfp_stream_if, tfp_parse_core and the macro header.
`timescale 1ns / 1ps
`include "tile_filename_parser_macros.svh"

module tile_filename_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tfp_stream_if.sink   i_chars,
    tfp_stream_if.source o_result,
    tfp_stream_if.sink   i_cfg
);
    import tfp_pkg::*;

    t_byte   r_skip_count;
    logic    r_flavors_en;
    logic    r_in_valid, n_in_valid;
    t_byte   r_in_char;
    logic    r_in_last;
    logic    r_out_valid, n_out_valid;
    t_result r_out_data;
    t_result core_result;

    logic    res_free;
    logic    advance;
    logic    in_acc;
    logic    cfg_acc;
    logic    out_reject;
    logic    out_zero;
    logic    flavor_legal;

    // configuration registers
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count <= '0;
            r_flavors_en <= 1'b1;
        end else if (cfg_acc) begin
            unique case (i_cfg.data.reg_index)
                CFG_SKIP_COUNT: r_skip_count <= i_cfg.data.write_data;
                CFG_FLAVORS_EN: r_flavors_en <= i_cfg.data.write_data[0];
                default: ;
            endcase
        end
    end

    // input register: moves on unless a last beat meets a full result slot
    assign res_free      = !r_out_valid || o_result.ready;
    assign advance       = r_in_valid && (!r_in_last || res_free);
    assign i_chars.ready = !r_in_valid || advance;
    assign in_acc        = i_chars.valid && i_chars.ready;
    assign n_in_valid    = in_acc || (r_in_valid && !advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_char <= i_chars.data.char_code;
            r_in_last <= i_chars.data.is_last;
        end
    end

    tfp_parse_core u_parse_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .i_skip_count (r_skip_count),
        .i_flavors_en (r_flavors_en),
        .o_result     (core_result)
    );

    // result register
    assign n_out_valid = (advance && r_in_last) || (r_out_valid && !o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_data <= core_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    // check terms
    assign out_reject   = r_out_valid && !r_out_data.name_valid;
    assign out_zero     = (r_out_data.level_of_detail == 8'd0) &&
                          (r_out_data.tile_x == 32'd0) && (r_out_data.tile_y == 32'd0) &&
                          (r_out_data.sub_file == 32'd0) && !r_out_data.has_sub_file &&
                          (r_out_data.file_type == TYPE_META) &&
                          (r_out_data.flavor_code == FLAVOR_REGULAR);
    assign flavor_legal = (r_out_data.flavor_code == FLAVOR_REGULAR) ||
                          (r_out_data.flavor_code == FLAVOR_RAW) ||
                          (r_out_data.flavor_code == FLAVOR_DEBUG);

    // checks
    `TFP_ASSERT_IMP(a_reject_zero, i_clk, i_rst_n, out_reject, out_zero)
    `TFP_ASSERT_IMP(a_flavor_range, i_clk, i_rst_n, r_out_valid, flavor_legal)
    `TFP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)

endmodule

@@ src/tfp_ext_lookup.sv @@
// Extension resolver: picks the first surviving extension whose length
// equals the characters seen. Uses tfp_pkg tables.
`timescale 1ns / 1ps

module tfp_ext_lookup (
    input  logic [tfp_pkg::EXT_COUNT-1:0] i_alive,
    input  logic [tfp_pkg::POS_W-1:0]     i_pos,
    input  logic                          i_flavors_en,
    output tfp_pkg::t_ext_hit             o_hit
);
    import tfp_pkg::*;

    // lowest matching index wins; raw and debug names need flavors enabled
    always_comb begin
        o_hit = '0;
        for (int i = EXT_COUNT - 1; i >= 0; i--) begin
            if (i_alive[i] && (i_pos == EXT_LEN[i]) &&
                ((i < REGULAR_COUNT) || i_flavors_en)) begin
                o_hit.found     = 1'b1;
                o_hit.file_type = EXT_TYPE[i];
                o_hit.flavor    = EXT_FLAVOR[i];
            end
        end
    end

endmodule

@@ src/tfp_parse_core.sv @@
// Per-character parse state and next-state logic; forms the result for the
// last character. Depends on tfp_pkg, tfp_ext_lookup and the macro header.
`timescale 1ns / 1ps
`include "tile_filename_parser_macros.svh"

module tfp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  tfp_pkg::t_byte    i_char,
    input  logic              i_last,
    input  tfp_pkg::t_byte    i_skip_count,
    input  logic              i_flavors_en,
    output tfp_pkg::t_result  o_result
);
    import tfp_pkg::*;

    // parse phases
    localparam logic [2:0] PH_SKIP = 3'd0;
    localparam logic [2:0] PH_LOD  = 3'd1;
    localparam logic [2:0] PH_X    = 3'd2;
    localparam logic [2:0] PH_Y    = 3'd3;
    localparam logic [2:0] PH_SUB  = 3'd4;
    localparam logic [2:0] PH_EXT  = 3'd5;
    localparam logic [2:0] PH_HELD = 3'd6;

    localparam logic [EXT_COUNT-1:0] ALL_ALIVE = '1;

    logic [2:0]           r_phase, n_phase;
    t_byte                r_skip_cnt, n_skip_cnt;
    logic [31:0]          r_acc, n_acc;
    logic                 r_has_digit, n_has_digit;
    logic                 r_lz, n_lz;
    logic [7:0]           r_lod, n_lod;
    logic [31:0]          r_x, n_x;
    logic [31:0]          r_y, n_y;
    logic [31:0]          r_sub, n_sub;
    logic                 r_sub_present, n_sub_present;
    logic [EXT_COUNT-1:0] r_alive, n_alive;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_error, n_error;

    logic [EXT_COUNT-1:0] keep;
    logic [35:0]          acc10;
    logic [35:0]          limit;
    logic [2:0]           cur;
    logic                 is_digit;
    t_ext_hit             hit;
    logic                 need_sub;
    logic                 name_ok;
    logic                 last_step;
    logic                 at_start;

    // extension survivors for the current character
    always_comb begin
        for (int i = 0; i < EXT_COUNT; i++) begin
            keep[i] = (r_pos < EXT_LEN[i]) && (r_pos < POS_W'(MAX_EXT_LEN)) &&
                      (EXT_TEXT[i][r_pos[EXT_POS_W-1:0]] == i_char);
        end
    end

    // decimal accumulate: acc*10 + digit as shift-add
    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign acc10    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                      {32'b0, 4'(i_char - CH_ZERO)};
    assign cur      = (r_phase == PH_SKIP) ? PH_LOD : r_phase;
    assign limit    = (cur == PH_LOD) ? 36'd255 : 36'hFFFF_FFFF;

    // next parse state after this character
    always_comb begin
        n_phase       = r_phase;
        n_skip_cnt    = r_skip_cnt;
        n_acc         = r_acc;
        n_has_digit   = r_has_digit;
        n_lz          = r_lz;
        n_lod         = r_lod;
        n_x           = r_x;
        n_y           = r_y;
        n_sub         = r_sub;
        n_sub_present = r_sub_present;
        n_alive       = r_alive;
        n_pos         = r_pos;
        n_error       = r_error;
        if (!r_error) begin
            if ((r_phase == PH_SKIP) && (r_skip_cnt < i_skip_count)) begin
                n_skip_cnt = r_skip_cnt + 8'd1;
            end else begin
                n_phase = cur;
                if (cur == PH_HELD) begin
                    // rest of the name after a NUL is ignored
                end else if (cur == PH_EXT) begin
                    if (i_char == CH_NUL) begin
                        n_phase = PH_HELD;
                    end else begin
                        n_alive = r_alive & keep;
                        if (r_pos != '1) begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                end else if (is_digit) begin
                    if (r_lz || (acc10 > limit)) begin
                        n_error = 1'b1;
                    end else begin
                        n_acc       = acc10[31:0];
                        n_has_digit = 1'b1;
                        if (!r_has_digit && (i_char == CH_ZERO)) begin
                            n_lz = 1'b1;
                        end
                    end
                end else if (!r_has_digit) begin
                    n_error = 1'b1;
                end else begin
                    // separator closes the current number
                    n_acc       = '0;
                    n_has_digit = 1'b0;
                    n_lz        = 1'b0;
                    unique case (cur)
                        PH_LOD: begin
                            n_lod = r_acc[7:0];
                            if (i_char == CH_DASH) n_phase = PH_X;
                            else n_error = 1'b1;
                        end
                        PH_X: begin
                            n_x = r_acc;
                            if (i_char == CH_DASH) n_phase = PH_Y;
                            else n_error = 1'b1;
                        end
                        PH_Y: begin
                            n_y = r_acc;
                            if (i_char == CH_DASH) begin
                                n_sub_present = 1'b1;
                                n_phase       = PH_SUB;
                            end else if (i_char == CH_DOT) begin
                                n_phase = PH_EXT;
                            end else begin
                                n_error = 1'b1;
                            end
                        end
                        default: begin
                            n_sub = r_acc;
                            if (i_char == CH_DOT) n_phase = PH_EXT;
                            else n_error = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    tfp_ext_lookup u_ext_lookup (
        .i_alive      (n_alive),
        .i_pos        (n_pos),
        .i_flavors_en (i_flavors_en),
        .o_hit        (hit)
    );

    // final verdict; every field zero when the name is rejected
    assign need_sub = ((hit.file_type == TYPE_ATLAS) || (hit.file_type == TYPE_ORTHO)) &&
                      (hit.flavor == FLAVOR_REGULAR);
    assign name_ok  = !n_error && ((n_phase == PH_EXT) || (n_phase == PH_HELD)) &&
                      (n_pos != '0) && hit.found && (need_sub == n_sub_present);

    always_comb begin
        o_result = '0;
        if (name_ok) begin
            o_result.name_valid      = 1'b1;
            o_result.level_of_detail = n_lod;
            o_result.tile_x          = n_x;
            o_result.tile_y          = n_y;
            o_result.sub_file        = n_sub_present ? n_sub : 32'd0;
            o_result.has_sub_file    = n_sub_present;
            o_result.file_type       = hit.file_type;
            o_result.flavor_code     = hit.flavor;
        end
    end

    assign last_step = i_step && i_last;
    assign at_start  = (r_phase == PH_SKIP) && !r_error;

    // state update; the last character returns to the start of a name
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || last_step) begin
            r_phase       <= PH_SKIP;
            r_skip_cnt    <= '0;
            r_acc         <= '0;
            r_has_digit   <= 1'b0;
            r_lz          <= 1'b0;
            r_lod         <= '0;
            r_x           <= '0;
            r_y           <= '0;
            r_sub         <= '0;
            r_sub_present <= 1'b0;
            r_alive       <= ALL_ALIVE;
            r_pos         <= '0;
            r_error       <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_skip_cnt    <= n_skip_cnt;
            r_acc         <= n_acc;
            r_has_digit   <= n_has_digit;
            r_lz          <= n_lz;
            r_lod         <= n_lod;
            r_x           <= n_x;
            r_y           <= n_y;
            r_sub         <= n_sub;
            r_sub_present <= n_sub_present;
            r_alive       <= n_alive;
            r_pos         <= n_pos;
            r_error       <= n_error;
        end
    end

    // checks
    `TFP_ASSERT_NXT(a_restart_after_last, i_clk, i_rst_n, last_step, at_start)
    `TFP_ASSERT_NXT(a_error_sticky, i_clk, i_rst_n, r_error && !last_step, r_error)
    `TFP_ASSERT_IMP(a_lod_bound, i_clk, i_rst_n, !r_error && (r_phase == PH_LOD), r_acc <= 32'd255)

endmodule
